/* src/assert_macros.svh */
// assertion macros shared by the parser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence checked in the cycle after the trigger, outside reset
`define ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

/* src/dhcprp_pkg.sv */
// types, constants and register map of the dhcp reply parser
package dhcprp_pkg;

  // payload length limit and byte position counter
  localparam int MAX_PAYLOAD   = 1024;
  localparam int POS_W         = $clog2(MAX_PAYLOAD + 1);
  localparam int OPTIONS_START = 240;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;
  localparam logic [1:0] REG_TRANSACTION_ID = 2'd0;
  localparam logic [1:0] REG_CLIENT_MAC     = 2'd1;
  localparam logic [1:0] REG_TIME_OPTION    = 2'd2;
  localparam logic [7:0] TIME_OPTION_RESET  = 8'd42;

  // input actions
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_PAYLOAD = 1'b1;

  // fixed header bytes and their positions
  localparam logic [7:0] HDR_OP_REPLY   = 8'd2;
  localparam logic [7:0] HDR_HTYPE_ETH  = 8'd1;
  localparam logic [7:0] HDR_HLEN_MAC   = 8'd6;
  localparam logic [7:0] POS_OP         = 8'd0;
  localparam logic [7:0] POS_HTYPE      = 8'd1;
  localparam logic [7:0] POS_HLEN       = 8'd2;
  localparam logic [7:0] POS_XID_FIRST  = 8'd4;
  localparam logic [7:0] POS_XID_LAST   = 8'd7;
  localparam logic [7:0] POS_YIADDR_FIRST = 8'd16;
  localparam logic [7:0] POS_YIADDR_LAST  = 8'd19;
  localparam logic [7:0] POS_MAC_FIRST  = 8'd28;
  localparam logic [7:0] POS_MAC_LAST   = 8'd33;
  localparam logic [7:0] POS_COOKIE_FIRST = 8'd236;

  typedef logic [7:0] cookie_t [4];
  localparam cookie_t COOKIE = '{8'd99, 8'd130, 8'd83, 8'd99};

  // option codes and message types
  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_NETMASK  = 8'd1;
  localparam logic [7:0] OPT_ROUTER   = 8'd3;
  localparam logic [7:0] OPT_DNS      = 8'd6;
  localparam logic [7:0] OPT_MSGTYPE  = 8'd53;
  localparam logic [7:0] OPT_SERVER   = 8'd54;
  localparam logic [7:0] OPT_END      = 8'hff;
  localparam logic [7:0] MSG_OFFER    = 8'd2;
  localparam logic [7:0] MSG_ACK      = 8'd5;
  localparam logic [7:0] LEN_ADDRESS  = 8'd4;
  localparam logic [7:0] LEN_MSGTYPE  = 8'd1;

  // capture slots
  localparam int CAP_COUNT   = 6;
  localparam int CAP_OFFERED = 0;
  localparam int CAP_SERVER  = 1;
  localparam int CAP_NETMASK = 2;
  localparam int CAP_ROUTER  = 3;
  localparam int CAP_DNS     = 4;
  localparam int CAP_TIME    = 5;

  typedef enum logic [1:0] {
    PH_CLOSED   = 2'd0,
    PH_DISCOVER = 2'd1,
    PH_REQUEST  = 2'd2,
    PH_ACK      = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    OS_CODE   = 2'd0,
    OS_LENGTH = 2'd1,
    OS_VALUE  = 2'd2
  } opt_step_t;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic        header_ok;
    logic [7:0]  message_type;
    logic        send_request;
    logic [31:0] offered_ip;
    logic [31:0] server_ip;
    logic [31:0] netmask;
    logic [31:0] router_ip;
    logic [31:0] dns_ip;
    logic [31:0] time_server_ip;
  } out_item_t;

  typedef struct packed {
    logic [31:0] transaction_id;
    logic [47:0] client_mac;
    logic [7:0]  time_server_option;
  } cfg_t;

endpackage

/* src/dhcprp_parse.sv */
// per-byte parse state, header checks, option walk and captures
`include "assert_macros.svh"

module dhcprp_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  dhcprp_pkg::in_item_t  item,
  input  dhcprp_pkg::cfg_t      cfg,
  output logic                  result_fire,
  output dhcprp_pkg::out_item_t result
);

  // persistent state
  dhcprp_pkg::phase_t    phase, phase_next, phase_upd;
  logic [31:0]           captured [dhcprp_pkg::CAP_COUNT];
  logic [31:0]           captured_next [dhcprp_pkg::CAP_COUNT];
  logic [31:0]           captured_upd [dhcprp_pkg::CAP_COUNT];

  // per-packet state
  dhcprp_pkg::pos_t      pos, pos_next, pos_upd;
  logic                  header_match, header_match_next, header_match_upd;
  dhcprp_pkg::opt_step_t option_step, option_step_next, option_step_upd;
  logic [7:0]            option_code, option_code_next, option_code_upd;
  logic [7:0]            option_remaining, option_remaining_next, option_remaining_upd;
  logic [7:0]            option_length, option_length_next, option_length_upd;
  logic [31:0]           value_shift, value_shift_next, value_shift_upd;
  logic                  options_done, options_done_next, options_done_upd;
  logic [7:0]            seen_type, seen_type_next, seen_type_upd;
  logic [31:0]           offer_hold, offer_hold_next, offer_hold_upd;

  // helpers
  logic [7:0]  b;
  logic [7:0]  hpos;
  logic [7:0]  want;
  logic [1:0]  xid_sel;
  logic [2:0]  mac_sel;
  logic [7:0]  k;
  logic        hdr_ok;
  logic        send;

  assign b       = item.data_byte;
  assign hpos    = pos[7:0];
  assign xid_sel = 2'd3 - hpos[1:0];
  assign mac_sel = 3'(hpos - dhcprp_pkg::POS_MAC_FIRST);
  assign k       = option_length - option_remaining;

  // effect of one payload byte
  always_comb begin
    phase_upd            = phase;
    captured_upd         = captured;
    pos_upd              = pos;
    header_match_upd     = header_match;
    option_step_upd      = option_step;
    option_code_upd      = option_code;
    option_remaining_upd = option_remaining;
    option_length_upd    = option_length;
    value_shift_upd      = value_shift;
    options_done_upd     = options_done;
    seen_type_upd        = seen_type;
    offer_hold_upd       = offer_hold;
    want                 = b;
    hdr_ok               = 1'b0;
    send                 = 1'b0;

    if (pos < dhcprp_pkg::pos_t'(dhcprp_pkg::MAX_PAYLOAD)) begin
      pos_upd = pos + dhcprp_pkg::pos_t'(1);
      if (pos < dhcprp_pkg::pos_t'(dhcprp_pkg::OPTIONS_START)) begin
        // fixed header fields
        if (hpos == dhcprp_pkg::POS_OP) begin
          want = dhcprp_pkg::HDR_OP_REPLY;
        end else if (hpos == dhcprp_pkg::POS_HTYPE) begin
          want = dhcprp_pkg::HDR_HTYPE_ETH;
        end else if (hpos == dhcprp_pkg::POS_HLEN) begin
          want = dhcprp_pkg::HDR_HLEN_MAC;
        end else if (hpos >= dhcprp_pkg::POS_XID_FIRST && hpos <= dhcprp_pkg::POS_XID_LAST) begin
          want = cfg.transaction_id[{xid_sel, 3'b000} +: 8];
        end else if (hpos >= dhcprp_pkg::POS_YIADDR_FIRST &&
                     hpos <= dhcprp_pkg::POS_YIADDR_LAST) begin
          offer_hold_upd[{hpos[1:0], 3'b000} +: 8] = b;
        end else if (hpos >= dhcprp_pkg::POS_MAC_FIRST && hpos <= dhcprp_pkg::POS_MAC_LAST) begin
          want = cfg.client_mac[{mac_sel, 3'b000} +: 8];
        end else if (hpos >= dhcprp_pkg::POS_COOKIE_FIRST) begin
          want = dhcprp_pkg::COOKIE[hpos[1:0]];
        end
        if (want != b) begin
          header_match_upd = 1'b0;
        end
      end else if (!options_done) begin
        // option list walk
        unique case (option_step)
          dhcprp_pkg::OS_CODE: begin
            if (b == dhcprp_pkg::OPT_END) begin
              options_done_upd = 1'b1;
            end else if (b != dhcprp_pkg::OPT_PAD) begin
              option_code_upd = b;
              option_step_upd = dhcprp_pkg::OS_LENGTH;
            end
          end
          dhcprp_pkg::OS_LENGTH: begin
            option_length_upd    = b;
            option_remaining_upd = b;
            value_shift_upd      = '0;
            option_step_upd      = (b == 8'd0) ? dhcprp_pkg::OS_CODE : dhcprp_pkg::OS_VALUE;
          end
          dhcprp_pkg::OS_VALUE: begin
            if (k < 8'd4) begin
              value_shift_upd = value_shift | (32'(b) << {k[1:0], 3'b000});
            end
            if (option_code == dhcprp_pkg::OPT_MSGTYPE &&
                option_length == dhcprp_pkg::LEN_MSGTYPE) begin
              seen_type_upd = b;
            end
            option_remaining_upd = option_remaining - 8'd1;
            if (option_remaining_upd == 8'd0) begin
              option_step_upd = dhcprp_pkg::OS_CODE;
              if (option_length == dhcprp_pkg::LEN_ADDRESS && header_match &&
                  phase == dhcprp_pkg::PH_DISCOVER) begin
                // fixed codes win over the configured time server code
                priority if (option_code == dhcprp_pkg::OPT_NETMASK) begin
                  captured_upd[dhcprp_pkg::CAP_NETMASK] = value_shift_upd;
                end else if (option_code == dhcprp_pkg::OPT_ROUTER) begin
                  captured_upd[dhcprp_pkg::CAP_ROUTER] = value_shift_upd;
                end else if (option_code == dhcprp_pkg::OPT_DNS) begin
                  captured_upd[dhcprp_pkg::CAP_DNS] = value_shift_upd;
                end else if (option_code == dhcprp_pkg::OPT_SERVER) begin
                  captured_upd[dhcprp_pkg::CAP_SERVER] = value_shift_upd;
                end else if (option_code == dhcprp_pkg::OPT_MSGTYPE) begin
                  captured_upd[dhcprp_pkg::CAP_SERVER] = captured[dhcprp_pkg::CAP_SERVER];
                end else if (option_code == cfg.time_server_option) begin
                  captured_upd[dhcprp_pkg::CAP_TIME] = value_shift_upd;
                end
              end
            end
          end
          default: begin
            option_step_upd = dhcprp_pkg::OS_CODE;
          end
        endcase
      end
    end

    // end of packet: header verdict, phase transitions, offered address capture and send request
    if (item.last) begin
      hdr_ok = header_match_upd &&
               (pos >= dhcprp_pkg::pos_t'(dhcprp_pkg::OPTIONS_START - 1));
      if (hdr_ok) begin
        if (phase == dhcprp_pkg::PH_DISCOVER && seen_type_upd == dhcprp_pkg::MSG_OFFER) begin
          captured_upd[dhcprp_pkg::CAP_OFFERED] = offer_hold_upd;
          phase_upd = dhcprp_pkg::PH_REQUEST;
          send      = 1'b1;
        end else if (phase == dhcprp_pkg::PH_REQUEST &&
                     seen_type_upd == dhcprp_pkg::MSG_ACK) begin
          phase_upd = dhcprp_pkg::PH_ACK;
        end
      end
    end
  end

  // next state selection
  always_comb begin
    phase_next            = phase;
    captured_next         = captured;
    pos_next              = pos;
    header_match_next     = header_match;
    option_step_next      = option_step;
    option_code_next      = option_code;
    option_remaining_next = option_remaining;
    option_length_next    = option_length;
    value_shift_next      = value_shift;
    options_done_next     = options_done;
    seen_type_next        = seen_type;
    offer_hold_next       = offer_hold;
    if (accept) begin
      if (item.action == dhcprp_pkg::ACT_START || item.last) begin
        // packet restart
        pos_next              = '0;
        header_match_next     = 1'b1;
        option_step_next      = dhcprp_pkg::OS_CODE;
        option_code_next      = '0;
        option_remaining_next = '0;
        option_length_next    = '0;
        value_shift_next      = '0;
        options_done_next     = 1'b0;
        seen_type_next        = '0;
        offer_hold_next       = '0;
      end else begin
        pos_next              = pos_upd;
        header_match_next     = header_match_upd;
        option_step_next      = option_step_upd;
        option_code_next      = option_code_upd;
        option_remaining_next = option_remaining_upd;
        option_length_next    = option_length_upd;
        value_shift_next      = value_shift_upd;
        options_done_next     = options_done_upd;
        seen_type_next        = seen_type_upd;
        offer_hold_next       = offer_hold_upd;
      end
      if (item.action == dhcprp_pkg::ACT_START) begin
        phase_next = dhcprp_pkg::PH_DISCOVER;
        for (int i = 0; i < dhcprp_pkg::CAP_COUNT; i++) begin
          captured_next[i] = '0;
        end
      end else begin
        phase_next    = phase_upd;
        captured_next = captured_upd;
      end
    end
  end

  // result item
  always_comb begin
    result_fire           = accept && item.action == dhcprp_pkg::ACT_PAYLOAD && item.last;
    result.phase          = phase_upd;
    result.header_ok      = hdr_ok;
    result.message_type   = seen_type_upd;
    result.send_request   = send;
    result.offered_ip     = captured_upd[dhcprp_pkg::CAP_OFFERED];
    result.server_ip      = captured_upd[dhcprp_pkg::CAP_SERVER];
    result.netmask        = captured_upd[dhcprp_pkg::CAP_NETMASK];
    result.router_ip      = captured_upd[dhcprp_pkg::CAP_ROUTER];
    result.dns_ip         = captured_upd[dhcprp_pkg::CAP_DNS];
    result.time_server_ip = captured_upd[dhcprp_pkg::CAP_TIME];
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= dhcprp_pkg::PH_CLOSED;
      pos              <= '0;
      header_match     <= 1'b1;
      option_step      <= dhcprp_pkg::OS_CODE;
      option_code      <= '0;
      option_remaining <= '0;
      option_length    <= '0;
      value_shift      <= '0;
      options_done     <= 1'b0;
      seen_type        <= '0;
      offer_hold       <= '0;
      for (int i = 0; i < dhcprp_pkg::CAP_COUNT; i++) begin
        captured[i] <= '0;
      end
    end else begin
      phase            <= phase_next;
      pos              <= pos_next;
      header_match     <= header_match_next;
      option_step      <= option_step_next;
      option_code      <= option_code_next;
      option_remaining <= option_remaining_next;
      option_length    <= option_length_next;
      value_shift      <= value_shift_next;
      options_done     <= options_done_next;
      seen_type        <= seen_type_next;
      offer_hold       <= offer_hold_next;
      captured         <= captured_next;
    end
  end

  // checks
  `ASSERT_RST(a_pos_bound, clk, rst, pos <= dhcprp_pkg::pos_t'(dhcprp_pkg::MAX_PAYLOAD), "byte position past limit")
  `ASSERT_RST(a_done_step, clk, rst, !options_done || option_step == dhcprp_pkg::OS_CODE, "option walk ended mid option")
  `ASSERT_NEXT(a_start_discover, clk, rst, accept && item.action == dhcprp_pkg::ACT_START, phase == dhcprp_pkg::PH_DISCOVER && pos == '0, "start did not enter discover")

endmodule

/* src/dhcp_reply_option_parser.sv */
// top level of the dhcp reply parser: config port, parse core and result queue
//
//   channel  | dir | signals                          | transfer when
//   item     | in  | item_valid item_ready item       | item_valid & item_ready
//   result   | out | result_valid result_ready result | result_valid & result_ready
//   config   | in  | psel penable pwrite paddr pwdata | psel & penable & pwrite (pready high)
//
// one payload byte per cycle while item_ready is high, parsed in the cycle it is taken
// a final byte's result is registered in the output entry, or the skid entry if that is full
// a two-entry result queue lets bytes keep flowing while a result waits
// item_ready drops only when both queue entries hold results
// rst is synchronous; all registers but the result and skid data take their reset values
`include "assert_macros.svh"

module dhcp_reply_option_parser (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  dhcprp_pkg::in_item_t                item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output dhcprp_pkg::out_item_t               result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dhcprp_pkg::ADDR_W-1:0]       paddr,
  input  logic [dhcprp_pkg::DATA_W-1:0]       pwdata,
  output logic [dhcprp_pkg::DATA_W-1:0]       prdata,
  output logic                                pready
);

  dhcprp_pkg::cfg_t      cfg;
  logic [1:0]            reg_sel;
  logic                  wr_en;
  logic                  accept;
  logic                  core_fire;
  dhcprp_pkg::out_item_t core_result;
  logic                  skid_valid;
  dhcprp_pkg::out_item_t skid;
  logic                  pop;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_sel = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.transaction_id     <= '0;
      cfg.client_mac         <= '0;
      cfg.time_server_option <= dhcprp_pkg::TIME_OPTION_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        dhcprp_pkg::REG_TRANSACTION_ID: cfg.transaction_id     <= pwdata[31:0];
        dhcprp_pkg::REG_CLIENT_MAC:     cfg.client_mac         <= pwdata[47:0];
        dhcprp_pkg::REG_TIME_OPTION:    cfg.time_server_option <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_sel)
      dhcprp_pkg::REG_TRANSACTION_ID: prdata = 64'(cfg.transaction_id);
      dhcprp_pkg::REG_CLIENT_MAC:     prdata = 64'(cfg.client_mac);
      dhcprp_pkg::REG_TIME_OPTION:    prdata = 64'(cfg.time_server_option);
      default:                        prdata = '0;
    endcase
  end

  // parse core
  assign item_ready = !skid_valid;
  assign accept     = item_valid && item_ready;

  dhcprp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (item),
    .cfg         (cfg),
    .result_fire (core_fire),
    .result      (core_result)
  );

  // two-entry result queue: output register plus skid entry
  assign pop = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) begin
          result_valid <= 1'b1;
          skid_valid   <= 1'b0;
        end
      end else if (result_valid) begin
        if (pop) begin
          result_valid <= core_fire;
        end else if (core_fire) begin
          skid_valid <= 1'b1;
        end
      end else begin
        result_valid <= core_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        result <= skid;
      end
    end else if (result_valid && !pop) begin
      if (core_fire) begin
        skid <= core_result;
      end
    end else if (core_fire) begin
      result <= core_result;
    end
  end

  // checks
  `ASSERT_RST(a_skid_order, clk, rst, !skid_valid || result_valid, "skid entry held without output entry")
  `ASSERT_RST(a_full_stall, clk, rst, !(skid_valid && accept), "byte taken with result queue full")
  `ASSERT_RST(a_send_phase, clk, rst, !(result_valid && result.send_request) || (result.phase == dhcprp_pkg::PH_REQUEST && result.header_ok), "send_request outside request phase")

endmodule
